[rtl/core/lia_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lia_pkg - shared types and constants for the lock-in I/Q magnitude averager
// Field widths, reset value of the averaging length, sequencer codes and
// small arithmetic helpers.
// ----------------------------------------------------------------------------
package lia_pkg;

  localparam int SAMPLE_W   = 16;
  localparam int REF_W      = 16;
  localparam int LEN_W      = 16;
  localparam int AVG_W      = 32;
  localparam int SQ_W       = 2 * AVG_W;
  localparam int DIV_STEPS  = AVG_W;
  localparam int ROOT_STEPS = SQ_W / 2;
  localparam int CNT_W      = $clog2(DIV_STEPS + 1);
  localparam int NUM_DIV    = 6;
  localparam int TERM_W     = AVG_W + 2;

  localparam logic [LEN_W-1:0] AVG_LEN_RESET = LEN_W'(1000);

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_MUL_Q,
    ST_MUL_I,
    ST_DIV_GO,
    ST_DIV_WAIT,
    ST_UPD_IQ,
    ST_SQ_Q,
    ST_SQ_I,
    ST_SUM,
    ST_ROOT_GO,
    ST_ROOT_WAIT,
    ST_UPD_R,
    ST_OUT
  } state_t;

  // division slots, run in this order
  typedef enum logic [2:0] {
    DIV_QX,   // |Q| / N
    DIV_QP,   // |sample*sine| / N
    DIV_IX,   // |I| / N
    DIV_IP,   // |sample*cosine| / N
    DIV_RM,   // R / N
    DIV_RT    // root / N
  } div_op_t;

  function automatic logic [AVG_W-1:0] abs32(input logic signed [AVG_W-1:0] v);
    logic [AVG_W-1:0] r;
    r = v[AVG_W-1] ? AVG_W'(-v) : AVG_W'(v);
    return r;
  endfunction

  // apply sign to a quotient magnitude
  function automatic logic signed [TERM_W-1:0] sterm(input logic [AVG_W-1:0] mag,
                                                     input logic neg);
    logic signed [TERM_W-1:0] m;
    m = $signed({2'b00, mag});
    return neg ? -m : m;
  endfunction

  function automatic logic signed [AVG_W-1:0] sat_s32(input logic signed [TERM_W-1:0] v);
    logic signed [AVG_W-1:0] r;
    if (v > $signed({{2{1'b0}}, 1'b0, {(AVG_W-1){1'b1}}})) begin
      r = {1'b0, {(AVG_W-1){1'b1}}};
    end else if (v < $signed({{2{1'b1}}, 1'b1, {(AVG_W-1){1'b0}}})) begin
      r = {1'b1, {(AVG_W-1){1'b0}}};
    end else begin
      r = v[AVG_W-1:0];
    end
    return r;
  endfunction

endpackage

[rtl/core/lia_if.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lia_if - channel interfaces for the lock-in I/Q magnitude averager
// Sample input, result output and averaging-length write channels.
// ----------------------------------------------------------------------------
interface lia_in_if import lia_pkg::*;;
  logic                       valid;
  logic                       ready;
  logic signed [SAMPLE_W-1:0] adc_sample;
  logic        [REF_W-1:0]    sine_ref;
  logic        [REF_W-1:0]    cosine_ref;

  modport source (output valid, adc_sample, sine_ref, cosine_ref, input ready);
  modport sink   (input valid, adc_sample, sine_ref, cosine_ref, output ready);
endinterface

interface lia_out_if import lia_pkg::*;;
  logic                    valid;
  logic                    ready;
  logic signed [AVG_W-1:0] quadrature_out;
  logic signed [AVG_W-1:0] in_phase_out;
  logic        [AVG_W-1:0] magnitude_out;

  modport source (output valid, quadrature_out, in_phase_out, magnitude_out, input ready);
  modport sink   (input valid, quadrature_out, in_phase_out, magnitude_out, output ready);
endinterface

interface lia_cfg_if import lia_pkg::*;;
  logic             valid;
  logic             ready;
  logic [LEN_W-1:0] averaging_length;

  modport source (output valid, averaging_length, input ready);
  modport sink   (input valid, averaging_length, output ready);
endinterface

[rtl/core/lia_div.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lia_div - serial unsigned divider
// Restoring division of a 32-bit dividend by a nonzero 16-bit divisor,
// one quotient bit per cycle.
// ----------------------------------------------------------------------------
module lia_div import lia_pkg::*; (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  input  logic [AVG_W-1:0] dividend,
  input  logic [LEN_W-1:0] divisor,
  output logic             busy,
  output logic             done,
  output logic [AVG_W-1:0] quotient
);

  logic [AVG_W-1:0] quo;
  logic [LEN_W-1:0] rem;
  logic [LEN_W-1:0] dvs;
  logic [CNT_W-1:0] cnt;
  logic             running;
  logic [LEN_W:0]   shifted;
  logic [LEN_W:0]   diff;
  logic             fits;

  assign shifted = {rem, quo[AVG_W-1]};
  assign diff    = shifted - {1'b0, dvs};
  assign fits    = shifted >= {1'b0, dvs};

  always_ff @(posedge clk) begin
    if (rst) begin
      running <= 1'b0;
      done    <= 1'b0;
      cnt     <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        running <= 1'b1;
        cnt     <= CNT_W'(DIV_STEPS);
      end else if (running) begin
        cnt <= cnt - CNT_W'(1);
        if (cnt == CNT_W'(1)) begin
          running <= 1'b0;
          done    <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      quo <= dividend;
      rem <= '0;
      dvs <= divisor;
    end else if (running) begin
      quo <= {quo[AVG_W-2:0], fits};
      rem <= fits ? diff[LEN_W-1:0] : shifted[LEN_W-1:0];
    end
  end

  assign busy     = running;
  assign quotient = quo;

endmodule

[rtl/core/lia_sqrt.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lia_sqrt - serial integer square root
// Floor square root of a 64-bit value, one root bit per cycle.
// ----------------------------------------------------------------------------
module lia_sqrt import lia_pkg::*; (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  input  logic [SQ_W-1:0]  radicand,
  output logic             done,
  output logic [AVG_W-1:0] root
);

  localparam int REM_W = AVG_W + 1;

  logic [SQ_W-1:0]  val;
  logic [REM_W-1:0] rem;
  logic [AVG_W-1:0] rt;
  logic [CNT_W-1:0] cnt;
  logic             running;
  logic [REM_W+1:0] rem_sh;
  logic [REM_W+1:0] trial;
  logic [REM_W+1:0] diff;
  logic             fits;

  assign rem_sh = {rem, val[SQ_W-1:SQ_W-2]};
  assign trial  = {1'b0, rt, 2'b01};
  assign diff   = rem_sh - trial;
  assign fits   = rem_sh >= trial;

  always_ff @(posedge clk) begin
    if (rst) begin
      running <= 1'b0;
      done    <= 1'b0;
      cnt     <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        running <= 1'b1;
        cnt     <= CNT_W'(ROOT_STEPS);
      end else if (running) begin
        cnt <= cnt - CNT_W'(1);
        if (cnt == CNT_W'(1)) begin
          running <= 1'b0;
          done    <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      val <= radicand;
      rem <= '0;
      rt  <= '0;
    end else if (running) begin
      val <= {val[SQ_W-3:0], 2'b00};
      rem <= fits ? diff[REM_W-1:0] : rem_sh[REM_W-1:0];
      rt  <= {rt[AVG_W-2:0], fits};
    end
  end

  assign root = rt;

endmodule

[rtl/core/lockin_iq_magnitude_averager_top.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lockin_iq_magnitude_averager_top - lock-in demodulator with running averages
// Forms sample*sine and sample*cosine, folds them into running averages Q and
// I (X - X/N + p/N, truncating toward zero, saturating), then averages the
// floor square root of Q*Q+I*I into the magnitude R the same way.
// ----------------------------------------------------------------------------
// Work per sample beat: six serial divides, one serial root and the
//   sequencer steps between them, all on the shared units.
// Samples: a new sample is accepted only in the idle state, after the last
//   one has left the output step, which waits while a full result register holds.
// Reset (rst, synchronous): averages clear to zero, averaging length returns
//   to 1000, sequencer goes idle and the result register empties.

module lockin_iq_magnitude_averager_top import lia_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  lia_cfg_if.sink   cfg,
  lia_in_if.sink    samples,
  lia_out_if.source results
);

  // --------------------------------------------------------------------------
  // State
  // --------------------------------------------------------------------------
  state_t                  state;
  state_t                  state_next;
  div_op_t                 div_op;

  logic [LEN_W-1:0]        avg_len;     // configured N
  logic [LEN_W-1:0]        n_eff;       // N latched per sample, zero taken as one

  logic signed [AVG_W-1:0] q_avg;
  logic signed [AVG_W-1:0] i_avg;
  logic        [AVG_W-1:0] m_avg;

  // latched sample beat
  logic [SAMPLE_W:0]       smag;        // |sample|, up to 2^15
  logic                    s_neg;
  logic [REF_W-1:0]        sine;
  logic [REF_W-1:0]        cosine;

  logic [AVG_W-1:0]        pq_mag;
  logic [AVG_W-1:0]        pi_mag;
  logic [AVG_W-1:0]        quo [NUM_DIV];
  logic [SQ_W-1:0]         sq_q;
  logic [SQ_W-1:0]         sq_i;
  logic [SQ_W-1:0]         sum_sq;
  logic [AVG_W-1:0]        root_val;

  // result register
  logic                    res_valid;
  logic signed [AVG_W-1:0] res_q;
  logic signed [AVG_W-1:0] res_i;
  logic        [AVG_W-1:0] res_m;

  // sequencer outputs
  logic                    in_ready;
  logic                    div_start;
  logic                    root_start;
  logic                    out_load;

  // --------------------------------------------------------------------------
  // Shared units
  // --------------------------------------------------------------------------
  logic [AVG_W-1:0] div_dividend;
  logic [AVG_W-1:0] div_quotient;
  logic             div_busy;
  logic             div_done;
  logic [AVG_W-1:0] root_out;
  logic             root_done;

  lia_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (div_dividend),
    .divisor  (n_eff),
    .busy     (div_busy),
    .done     (div_done),
    .quotient (div_quotient)
  );

  lia_sqrt u_sqrt (
    .clk      (clk),
    .rst      (rst),
    .start    (root_start),
    .radicand (sum_sq),
    .done     (root_done),
    .root     (root_out)
  );

  // dividend picked per division slot
  always_comb begin
    case (div_op)
      DIV_QX:  div_dividend = abs32(q_avg);
      DIV_QP:  div_dividend = pq_mag;
      DIV_IX:  div_dividend = abs32(i_avg);
      DIV_IP:  div_dividend = pi_mag;
      DIV_RM:  div_dividend = m_avg;
      DIV_RT:  div_dividend = root_val;
      default: div_dividend = '0;
    endcase
  end

  // one 32x32 multiplier, shared by the two products and the two squares;
  // every product lands in a register
  logic [AVG_W-1:0] mul_a;
  logic [AVG_W-1:0] mul_b;
  logic [SQ_W-1:0]  mul_p;

  always_comb begin
    case (state)
      ST_MUL_Q: begin
        mul_a = AVG_W'(smag);
        mul_b = AVG_W'(sine);
      end
      ST_MUL_I: begin
        mul_a = AVG_W'(smag);
        mul_b = AVG_W'(cosine);
      end
      ST_SQ_Q: begin
        mul_a = abs32(q_avg);
        mul_b = abs32(q_avg);
      end
      ST_SQ_I: begin
        mul_a = abs32(i_avg);
        mul_b = abs32(i_avg);
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  assign mul_p = mul_a * mul_b;

  // --------------------------------------------------------------------------
  // Average updates
  // --------------------------------------------------------------------------
  logic signed [TERM_W-1:0] q_new;
  logic signed [TERM_W-1:0] i_new;
  logic        [AVG_W:0]    r_new;

  assign q_new = $signed({{2{q_avg[AVG_W-1]}}, q_avg})
               - sterm(quo[DIV_QX], q_avg[AVG_W-1]) + sterm(quo[DIV_QP], s_neg);
  assign i_new = $signed({{2{i_avg[AVG_W-1]}}, i_avg})
               - sterm(quo[DIV_IX], i_avg[AVG_W-1]) + sterm(quo[DIV_IP], s_neg);
  // R - R/N never goes negative, so only the top can overflow
  assign r_new = {1'b0, m_avg} - {1'b0, quo[DIV_RM]} + {1'b0, quo[DIV_RT]};

  // --------------------------------------------------------------------------
  // Sequencer: next state
  // --------------------------------------------------------------------------
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE:      if (samples.valid) state_next = ST_MUL_Q;
      ST_MUL_Q:     state_next = ST_MUL_I;
      ST_MUL_I:     state_next = ST_DIV_GO;
      ST_DIV_GO:    state_next = ST_DIV_WAIT;
      ST_DIV_WAIT: begin
        if (div_done) begin
          if (div_op == DIV_IP) begin
            state_next = ST_UPD_IQ;
          end else if (div_op == DIV_RT) begin
            state_next = ST_UPD_R;
          end else begin
            state_next = ST_DIV_GO;
          end
        end
      end
      ST_UPD_IQ:    state_next = ST_SQ_Q;
      ST_SQ_Q:      state_next = ST_SQ_I;
      ST_SQ_I:      state_next = ST_SUM;
      ST_SUM:       state_next = ST_ROOT_GO;
      ST_ROOT_GO:   state_next = ST_ROOT_WAIT;
      ST_ROOT_WAIT: if (root_done) state_next = ST_DIV_GO;
      ST_UPD_R:     state_next = ST_OUT;
      ST_OUT:       if (!res_valid || results.ready) state_next = ST_IDLE;
      default:      state_next = ST_IDLE;
    endcase
  end

  // --------------------------------------------------------------------------
  // Sequencer: outputs
  // --------------------------------------------------------------------------
  always_comb begin
    in_ready   = 1'b0;
    div_start  = 1'b0;
    root_start = 1'b0;
    out_load   = 1'b0;
    case (state)
      ST_IDLE:    in_ready   = 1'b1;
      ST_DIV_GO:  div_start  = 1'b1;
      ST_ROOT_GO: root_start = 1'b1;
      ST_OUT:     out_load   = !res_valid || results.ready;
      default:    ;
    endcase
  end

  // --------------------------------------------------------------------------
  // Control registers
  // --------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      div_op    <= DIV_QX;
      avg_len   <= AVG_LEN_RESET;
      q_avg     <= '0;
      i_avg     <= '0;
      m_avg     <= '0;
      res_valid <= 1'b0;
    end else begin
      state <= state_next;

      if (cfg.valid) begin
        avg_len <= cfg.averaging_length;
      end

      if (state == ST_IDLE) begin
        div_op <= DIV_QX;
      end else if (state == ST_ROOT_WAIT && root_done) begin
        div_op <= DIV_RM;
      end else if (state == ST_DIV_WAIT && div_done && div_op != DIV_IP
                   && div_op != DIV_RT) begin
        div_op <= div_op_t'(div_op + 3'd1);
      end

      if (state == ST_UPD_IQ) begin
        q_avg <= sat_s32(q_new);
        i_avg <= sat_s32(i_new);
      end
      if (state == ST_UPD_R) begin
        m_avg <= r_new[AVG_W] ? {AVG_W{1'b1}} : r_new[AVG_W-1:0];
      end

      if (out_load) begin
        res_valid <= 1'b1;
      end else if (results.ready) begin
        res_valid <= 1'b0;
      end
    end
  end

  // --------------------------------------------------------------------------
  // Datapath registers
  // --------------------------------------------------------------------------
  logic signed [SAMPLE_W:0] s_ext;

  assign s_ext = {samples.adc_sample[SAMPLE_W-1], samples.adc_sample};

  always_ff @(posedge clk) begin
    if (samples.valid && in_ready) begin
      smag   <= s_ext[SAMPLE_W] ? (SAMPLE_W+1)'(-s_ext) : (SAMPLE_W+1)'(s_ext);
      s_neg  <= s_ext[SAMPLE_W];
      sine   <= samples.sine_ref;
      cosine <= samples.cosine_ref;
      n_eff  <= (avg_len == '0) ? LEN_W'(1) : avg_len;
    end
    if (state == ST_MUL_Q) pq_mag <= mul_p[AVG_W-1:0];
    if (state == ST_MUL_I) pi_mag <= mul_p[AVG_W-1:0];
    if (state == ST_SQ_Q)  sq_q   <= mul_p;
    if (state == ST_SQ_I)  sq_i   <= mul_p;
    if (state == ST_SUM)   sum_sq <= sq_q + sq_i;
    if (state == ST_ROOT_WAIT && root_done) root_val <= root_out;
    if (state == ST_DIV_WAIT && div_done)   quo[div_op] <= div_quotient;
    if (out_load) begin
      res_q <= q_avg;
      res_i <= i_avg;
      res_m <= m_avg;
    end
  end

  // --------------------------------------------------------------------------
  // Ports
  // --------------------------------------------------------------------------
  assign cfg.ready              = 1'b1;
  assign samples.ready          = in_ready;
  assign results.valid          = res_valid;
  assign results.quadrature_out = res_q;
  assign results.in_phase_out   = res_i;
  assign results.magnitude_out  = res_m;

`ifndef SYNTHESIS
  a_accept_starts: assert property (@(posedge clk) disable iff (rst)
    (samples.valid && samples.ready) |=> (state == ST_MUL_Q))
    else $error("sample beat did not start the product step");

  a_div_free: assert property (@(posedge clk) disable iff (rst)
    div_start |-> !div_busy)
    else $error("divider started while busy");

  a_div_done_waited: assert property (@(posedge clk) disable iff (rst)
    div_done |-> (state == ST_DIV_WAIT))
    else $error("divider finished outside its wait state");

  a_root_then_r: assert property (@(posedge clk) disable iff (rst)
    root_done |=> (state == ST_DIV_GO && div_op == DIV_RM))
    else $error("root did not hand over to the magnitude divides");
`endif

endmodule
